/* rtl/mexp_pkg.sv */
package mexp_pkg;

  // Reset value of the modulus register, truncated to the word width where it is used.
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LAUNCH,
    ST_STEP,
    ST_FINISH
  } state_t;

endpackage

/* rtl/modular_exponentiation.sv */
// Raises base to exponent modulo the modulus register (reset 1000000007; a modulus
// of 0 acts as 1), scanning the exponent from its lowest bit. An item is taken when
// start is high and busy is low; done is high for exactly one cycle with the result on
// power_result and cannot be held off. A zero exponent returns 1 with done
// high in the cycle right after the transfer. Otherwise the base is first reduced in
// one multiplier pass, then each exponent bit up to the highest set one costs one pass
// of two bit-serial modular multipliers running side by side, one multiplier bit per
// cycle. The modulus is written through cfg_valid/cfg_ready while busy is low.
module modular_exponentiation #(
  parameter int WORD_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WORD_BITS-1:0] cfg_data,
  output logic                 done,
  output logic [WORD_BITS-1:0] power_result
);

  mexp_pkg::state_t state;
  mexp_pkg::state_t state_next;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] m_eff;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] sq;
  logic [WORD_BITS-1:0] esh;
  logic                 accept;
  logic                 mul_start;
  logic                 sqr_start;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS-1:0] mul_b;
  logic                 mul_done;
  logic                 sqr_done;
  logic [WORD_BITS-1:0] mul_prod;
  logic [WORD_BITS-1:0] sqr_prod;

  assign accept = start && (state == mexp_pkg::ST_IDLE);
  assign m_eff  = (modulus == '0) ? WORD_BITS'(1) : modulus;

  // The multiply unit first reduces the base (1 * base), then handles acc * sq.
  assign mul_a = (state inside {mexp_pkg::ST_IDLE, mexp_pkg::ST_REDUCE}) ? WORD_BITS'(1)
                                                                         : sq;
  assign mul_b = (state == mexp_pkg::ST_IDLE) ? base : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_BITS'(mexp_pkg::MODULUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (exponent == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_done) begin
          state_next = mexp_pkg::ST_LAUNCH;
        end
      end
      mexp_pkg::ST_LAUNCH: begin
        state_next = mexp_pkg::ST_STEP;
      end
      mexp_pkg::ST_STEP: begin
        if (mul_done) begin
          state_next = (esh[WORD_BITS-1:1] == '0) ? mexp_pkg::ST_FINISH
                                                  : mexp_pkg::ST_LAUNCH;
        end
      end
      mexp_pkg::ST_FINISH: begin
        state_next = mexp_pkg::ST_IDLE;
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state != mexp_pkg::ST_IDLE);
    cfg_ready = (state == mexp_pkg::ST_IDLE);
    done      = (state == mexp_pkg::ST_FINISH);
    mul_start = (state == mexp_pkg::ST_LAUNCH) || (accept && exponent != '0);
    sqr_start = (state == mexp_pkg::ST_LAUNCH);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      esh <= exponent;
      acc <= WORD_BITS'(1);
    end else if (state == mexp_pkg::ST_REDUCE && mul_done) begin
      sq <= mul_prod;
    end else if (state == mexp_pkg::ST_STEP && mul_done) begin
      if (esh[0]) begin
        acc <= mul_prod;
      end
      sq  <= sqr_prod;
      esh <= esh >> 1;
    end
  end

  assign power_result = acc;

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (m_eff),
    .done   (mul_done),
    .product(mul_prod)
  );

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_sqr (
    .clk    (clk),
    .rst    (rst),
    .start  (sqr_start),
    .a      (sq),
    .b      (sq),
    .m      (m_eff),
    .done   (sqr_done),
    .product(sqr_prod)
  );

  a_units_in_step: assert property (@(posedge clk) disable iff (rst)
    (state == mexp_pkg::ST_STEP) |-> (mul_done == sqr_done))
    else $error("multiply and square units out of step");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_no_cfg_when_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(modulus))
    else $error("modulus changed during a computation");

endmodule

/* rtl/mexp_mulmod.sv */
module mexp_mulmod #(
  parameter int WORD_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic [WORD_BITS-1:0] product
);

  localparam int CW = $clog2(WORD_BITS + 1);
  localparam int TW = WORD_BITS + 2;

  logic                 run;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] bsh;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] r_next;
  logic [TW-1:0]        t;
  logic [TW-1:0]        m1;
  logic [TW-1:0]        m2;

  // One multiplier bit per cycle, most significant first: r = 2r + bit*a, reduced.
  // With r < m and a <= m the sum stays below 3m, so at most two subtractions.
  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, r, 1'b0} + (bsh[WORD_BITS-1] ? {2'b00, a} : '0);
    if (t >= m2) begin
      r_next = WORD_BITS'(t - m2);
    end else if (t >= m1) begin
      r_next = WORD_BITS'(t - m1);
    end else begin
      r_next = WORD_BITS'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(WORD_BITS);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bsh <= b;
      r   <= '0;
    end else if (run) begin
      bsh <= bsh << 1;
      r   <= r_next;
    end
  end

  assign product = r;

  a_partial_reduced: assert property (@(posedge clk) disable iff (rst)
    run |-> (r < m))
    else $error("partial product not below modulus");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> (run && cnt == CW'(WORD_BITS)))
    else $error("start did not load the bit counter");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(run) && !run))
    else $error("done without a finished run");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int W = 31;
  typedef logic [W-1:0] word_t;
  localparam word_t WORD_MAX = {W{1'b1}};

  typedef struct {
    word_t base;
    word_t exponent;
  } power_req_t;

  typedef struct {
    word_t base;
    word_t exponent;
    word_t power;
  } power_check_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  word_t base = '0;
  word_t exponent = '0;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  word_t cfg_data = '0;
  logic  done;
  word_t power_result;

  power_req_t   pending_reqs[$];
  power_check_t expected_powers[$];
  word_t        modulus_q = word_t'(mexp_pkg::MODULUS_RESET);
  int           queued_total = 0;
  int           accepted_total = 0;
  int           error_count = 0;
  logic         taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;

  modular_exponentiation #(
    .WORD_BITS(W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base(base),
    .exponent(exponent),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .power_result(power_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Right-to-left square-and-multiply; a zero modulus reduces like a modulus of one.
  function automatic word_t mod_power(word_t b, word_t e, word_t m);
    longint unsigned sq;
    longint unsigned acc;
    longint unsigned mm;
    word_t rest;
    mm = (m == '0) ? 64'd1 : 64'(m);
    sq = 64'(b);
    acc = 64'd1;
    rest = e;
    while (rest != '0) begin
      if (rest[0]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      rest = rest >> 1;
    end
    return acc[W-1:0];
  endfunction

  // Driver: holds an item until its transfer, then moves on in bursts with gaps.
  always @(negedge clk) begin
    power_req_t req;
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 8);
      gap_left = 0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        base <= req.base;
        exponent <= req.exponent;
        start <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then records new transfers.
  always @(posedge clk) begin
    power_check_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (done) begin
        if (expected_powers.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t: unexpected result, expected none, actual power_result %0d",
                   $time, power_result);
        end else begin
          want = expected_powers.pop_front();
          if (power_result !== want.power) begin
            error_count = error_count + 1;
            $display("%0t: base %0d exponent %0d: expected power_result %0d, actual %0d",
                     $time, want.base, want.exponent, want.power, power_result);
          end
        end
      end
      if (start && !busy) begin
        want.base = base;
        want.exponent = exponent;
        want.power = mod_power(base, exponent, modulus_q);
        expected_powers.push_back(want);
        accepted_total = accepted_total + 1;
      end
    end
  end

  task automatic queue_req(input word_t b, input word_t e);
    power_req_t req;
    req.base = b;
    req.exponent = e;
    pending_reqs.push_back(req);
    queued_total = queued_total + 1;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (accepted_total != queued_total || expected_powers.size() != 0) @(negedge clk);
  endtask

  // The modulus is only changed once every queued item has produced its result.
  task automatic set_modulus(input word_t value);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    modulus_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    word_t moduli[10];
    word_t b;
    word_t e;
    word_t m;
    int    w;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset modulus.
    m = word_t'(mexp_pkg::MODULUS_RESET);
    queue_req('0, '0);
    queue_req('0, 1);
    queue_req('0, WORD_MAX);
    queue_req(WORD_MAX, '0);
    queue_req(WORD_MAX, 1);
    queue_req(WORD_MAX, WORD_MAX);
    queue_req(1, WORD_MAX);
    queue_req(2, 30);
    queue_req(3, word_t'(1) << (W - 1));
    queue_req(m, 7);
    queue_req(word_t'(m + 1), 5);
    queue_req(12345, word_t'(m - 2));
    queue_req(WORD_MAX, word_t'(m - 2));
    queue_req(2, 2);
    queue_req(word_t'(m - 1), 2);

    // Degenerate moduli: everything reduces to zero, a zero exponent still gives one.
    set_modulus('0);
    queue_req(5, '0);
    queue_req(5, 3);
    queue_req(WORD_MAX, WORD_MAX);
    set_modulus(1);
    queue_req(7, '0);
    queue_req(7, 9);
    queue_req(WORD_MAX, 1);

    moduli[0] = 2;
    moduli[1] = WORD_MAX;
    moduli[2] = '0;
    moduli[3] = 1;
    moduli[4] = 3;
    moduli[5] = word_t'($urandom_range(4, 1000));
    moduli[6] = 65537;
    moduli[7] = word_t'($urandom_range(2, 32'h7fff_ffff));
    moduli[8] = word_t'($urandom);
    moduli[9] = word_t'(mexp_pkg::MODULUS_RESET);

    foreach (moduli[p]) begin
      set_modulus(moduli[p]);
      m = moduli[p];
      for (int i = 0; i < 27; i++) begin
        case ($urandom_range(7))
          0: e = '0;
          1: e = word_t'($urandom_range(1, 16));
          2: begin
            w = $urandom_range(1, W);
            e = word_t'($urandom) & (WORD_MAX >> (W - w));
          end
          3: e = (m >= 2) ? word_t'(m - 2) : word_t'($urandom);
          4: e = word_t'(1) << $urandom_range(0, W - 1);
          default: e = word_t'($urandom);
        endcase
        case ($urandom_range(5))
          0: b = word_t'($urandom_range(0, 3));
          1: b = WORD_MAX - word_t'($urandom_range(0, 3));
          2: b = m + word_t'($urandom_range(0, 3));
          3: b = word_t'($urandom_range(0, 1000));
          default: b = word_t'($urandom);
        endcase
        queue_req(b, e);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

/* modular_exponentiation.f */
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
tb/sv/testbench.sv
